[hw/rtl/kqt_pkg.sv]
// ----------------------------------------------------------------------------
// kqt_pkg
// Types, codes and constants shared by the keyed quantity table modules.
// ----------------------------------------------------------------------------
package kqt_pkg;

    localparam int KQT_ENTRIES = 16;
    localparam int KEY_W       = 32;
    localparam int AMOUNT_W    = 32;
    localparam int COUNT_W     = 31;
    localparam int WORD_W      = KEY_W + COUNT_W;

    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    typedef enum logic [1:0] {
        REQ_ADD    = 2'd0,
        REQ_REMOVE = 2'd1,
        REQ_QUERY  = 2'd2,
        REQ_CLEAR  = 2'd3
    } t_req_kind;

    typedef enum logic [1:0] {
        STS_OK      = 2'd0,
        STS_BAD_ARG = 2'd1,
        STS_MISSING = 2'd2,
        STS_FULL    = 2'd3
    } t_status;

    typedef struct packed {
        t_req_kind                   req_type;
        logic [KEY_W-1:0]            item_key;
        logic signed [AMOUNT_W-1:0]  amount;
    } t_in;

    typedef struct packed {
        t_status              status;
        logic [COUNT_W-1:0]   count;
        logic                 has_enough;
        logic                 changed;
    } t_out;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_EXEC
    } t_state;

    typedef struct packed {
        logic load;
        logic scan;
        logic commit;
    } t_cmd;

    typedef struct packed {
        logic scan_done;
        logic out_free;
    } t_sts;

endpackage

[hw/rtl/kqt_ram.sv]
// ----------------------------------------------------------------------------
// kqt_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module kqt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [0:DEPTH-1];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[hw/rtl/kqt_ctrl.sv]
// ----------------------------------------------------------------------------
// kqt_ctrl
// Request sequencer: accept, scan the table, commit the update and result.
// ----------------------------------------------------------------------------
module kqt_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  kqt_pkg::t_sts      i_sts,
    output kqt_pkg::t_cmd      o_cmd
);
    import kqt_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (i_sts.scan_done) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (i_sts.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
            end
            S_EXEC: begin
                o_cmd.commit = i_sts.out_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule

[hw/rtl/kqt_dp.sv]
// ----------------------------------------------------------------------------
// kqt_dp
// Table datapath: valid bits, key/count memory, scan compare and update.
// ----------------------------------------------------------------------------
module kqt_dp #(
    parameter int ENTRIES = kqt_pkg::KQT_ENTRIES
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  kqt_pkg::t_in    i_in,
    input  kqt_pkg::t_cmd   i_cmd,
    output kqt_pkg::t_sts   o_sts,
    input  logic            i_out_ready,
    output logic            o_out_valid,
    output kqt_pkg::t_out   o_out
);
    import kqt_pkg::*;

    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W = $clog2(ENTRIES + 1);

    t_in                r_req;
    logic [ENTRIES-1:0] r_valid;
    logic [CNT_W-1:0]   r_scan_idx;
    logic [IDX_W-1:0]   r_cmp_idx;
    logic               r_cmp_live;
    logic               r_hit;
    logic [IDX_W-1:0]   r_hit_idx;
    logic [COUNT_W-1:0] r_hit_cnt;
    logic               r_free_ok;
    logic [IDX_W-1:0]   r_free_idx;
    logic               r_out_valid;
    t_out               r_out;

    logic               rd_en;
    logic [WORD_W-1:0]  rd_word;
    logic [KEY_W-1:0]   rd_key;
    logic [COUNT_W-1:0] rd_cnt;
    logic               match;
    logic               last_cmp;
    logic               amt_pos;
    logic               key_zero;
    logic               skip;
    logic [COUNT_W:0]   add_sum;
    logic [COUNT_W-1:0] add_new;
    logic               rem_short;
    logic [COUNT_W-1:0] rem_new;
    logic               we;
    logic [IDX_W-1:0]   waddr;
    logic [COUNT_W-1:0] wcnt;
    t_out               n_out;
    logic [ENTRIES-1:0] n_valid;

    assign rd_en    = i_cmd.scan && (r_scan_idx < CNT_W'(ENTRIES));
    assign rd_key   = rd_word[WORD_W-1:COUNT_W];
    assign rd_cnt   = rd_word[COUNT_W-1:0];
    assign match    = r_cmp_live && r_valid[r_cmp_idx] && (rd_key == r_req.item_key);
    assign last_cmp = r_cmp_live && (r_cmp_idx == IDX_W'(ENTRIES - 1));

    assign amt_pos  = !r_req.amount[AMOUNT_W-1] && (r_req.amount != '0);
    assign key_zero = (r_req.item_key == '0);
    assign skip     = (r_req.req_type == REQ_CLEAR) || key_zero ||
                      (((r_req.req_type == REQ_ADD) || (r_req.req_type == REQ_REMOVE))
                       && !amt_pos);

    assign o_sts.scan_done = skip || match || last_cmp;
    assign o_sts.out_free  = !r_out_valid || i_out_ready;

    kqt_ram #(
        .WIDTH (WORD_W),
        .DEPTH (ENTRIES),
        .AW    (IDX_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata ({r_req.item_key, wcnt}),
        .i_re    (rd_en),
        .i_raddr (r_scan_idx[IDX_W-1:0]),
        .o_rdata (rd_word)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_req      <= i_in;
            r_scan_idx <= '0;
            r_hit      <= 1'b0;
            r_free_ok  <= 1'b0;
        end else if (i_cmd.scan) begin
            if (rd_en) begin
                r_scan_idx <= r_scan_idx + CNT_W'(1);
            end
            r_cmp_idx <= r_scan_idx[IDX_W-1:0];
            if (match) begin
                r_hit     <= 1'b1;
                r_hit_idx <= r_cmp_idx;
                r_hit_cnt <= rd_cnt;
            end
            if (r_cmp_live && !r_valid[r_cmp_idx] && !r_free_ok) begin
                r_free_ok  <= 1'b1;
                r_free_idx <= r_cmp_idx;
            end
        end
        if (i_cmd.commit) begin
            r_out <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid     <= '0;
            r_cmp_live  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
            if (i_cmd.load) begin
                r_cmp_live <= 1'b0;
            end else if (i_cmd.scan) begin
                r_cmp_live <= rd_en;
            end
            if (i_cmd.commit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign add_sum   = {1'b0, r_hit_cnt} + {1'b0, r_req.amount[COUNT_W-1:0]};
    assign add_new   = add_sum[COUNT_W] ? COUNT_MAX : add_sum[COUNT_W-1:0];
    assign rem_short = ({1'b0, r_hit_cnt} < r_req.amount);
    assign rem_new   = r_hit_cnt - r_req.amount[COUNT_W-1:0];

    always_comb begin
        n_out   = '0;
        n_valid = r_valid;
        we      = 1'b0;
        waddr   = r_hit_idx;
        wcnt    = add_new;
        unique case (r_req.req_type)
            REQ_ADD: begin
                if (key_zero || !amt_pos) begin
                    n_out.status = STS_BAD_ARG;
                end else if (r_hit) begin
                    we            = 1'b1;
                    n_out.count   = add_new;
                    n_out.changed = 1'b1;
                end else if (r_free_ok) begin
                    we             = 1'b1;
                    waddr          = r_free_idx;
                    wcnt           = r_req.amount[COUNT_W-1:0];
                    n_valid[r_free_idx] = 1'b1;
                    n_out.count    = r_req.amount[COUNT_W-1:0];
                    n_out.changed  = 1'b1;
                end else begin
                    n_out.status = STS_FULL;
                end
            end
            REQ_REMOVE: begin
                wcnt = rem_new;
                if (key_zero || !amt_pos) begin
                    n_out.status = STS_BAD_ARG;
                end else if (!r_hit || rem_short) begin
                    n_out.status = STS_MISSING;
                end else begin
                    we            = 1'b1;
                    n_out.count   = rem_new;
                    n_out.changed = 1'b1;
                    if (rem_new == '0) begin
                        n_valid[r_hit_idx] = 1'b0;
                    end
                end
            end
            REQ_QUERY: begin
                n_out.count      = r_hit ? r_hit_cnt : '0;
                n_out.has_enough = ($signed({1'b0, n_out.count}) >= r_req.amount);
            end
            REQ_CLEAR: begin
                n_valid = '0;
            end
            default: begin
                n_out = '0;
            end
        endcase
        if (!i_cmd.commit) begin
            we      = 1'b0;
            n_valid = r_valid;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

[hw/rtl/keyed_quantity_table.sv]
// ----------------------------------------------------------------------------
// keyed_quantity_table
// Table of unique keys with saturating quantities: add, remove, query, clear.
// ----------------------------------------------------------------------------
// Each request returns exactly one result item. The block works on one item
// at a time: after acceptance it scans the key/count memory one entry per
// cycle through its single read port, stopping early on a key match and at
// once for a clear or rejected arguments, then commits the update and the
// result once the result register is free. Valid bits are flip-flops
// cleared by reset and by a clear request, so no clearing pass is needed. A
// new item is taken while the previous result still waits in the output
// register.
module keyed_quantity_table #(
    parameter int ENTRIES = kqt_pkg::KQT_ENTRIES
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  kqt_pkg::t_in   i_in,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output kqt_pkg::t_out  o_out
);
    import kqt_pkg::*;

    t_cmd cmd;
    t_sts sts;

    kqt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    kqt_dp #(
        .ENTRIES (ENTRIES)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .o_out       (o_out)
    );

endmodule

[hw/rtl/kqt_chk.sv]
// ----------------------------------------------------------------------------
// kqt_chk
// Port checker for the keyed quantity table, bound to the top level.
// ----------------------------------------------------------------------------
module kqt_chk (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           i_in_valid,
    input logic           o_in_ready,
    input logic           o_out_valid,
    input logic           i_out_ready,
    input kqt_pkg::t_out  o_out
);
    import kqt_pkg::*;

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("Result item present after reset.");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_out)))
        else $error("Stalled result item changed or vanished.");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("Item taken while the previous one is still at work.");

    a_fail_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out.status != STS_OK)) |->
        ((o_out.count == '0) && !o_out.changed && !o_out.has_enough))
        else $error("Failed request reports a count or a change.");

    a_enough_no_change: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out.has_enough) |-> !o_out.changed)
        else $error("Query result also reports a table change.");

endmodule

bind keyed_quantity_table kqt_chk u_chk (.*);

[test/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking test of the keyed quantity table.
// Directed requests cover argument checks, saturation, release to zero and a
// full table. Random add, remove, query and clear traffic on key pools of
// several sizes follows, with sender gaps, receiver stalls and one long
// output hold-off. Each result is checked in order against a table model.
// ----------------------------------------------------------------------------
module tb;
    import kqt_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 40;
    localparam int HOLD_CYCLES    = 250;
    localparam int POOL_MAX       = 40;

    logic i_clk       = 1'b0;
    logic i_rst_n     = 1'b0;
    logic i_in_valid  = 1'b0;
    logic o_in_ready;
    t_in  i_in        = '0;
    logic o_out_valid;
    logic i_out_ready = 1'b0;
    t_out o_out;

    logic               tbl_used [KQT_ENTRIES];
    logic [KEY_W-1:0]   tbl_key  [KQT_ENTRIES];
    logic [COUNT_W-1:0] tbl_qty  [KQT_ENTRIES];
    t_out               pending_replies[$];
    logic [KEY_W-1:0]   key_pool [POOL_MAX];

    int error_count  = 0;
    int quiet_cycles = 0;
    int hold_request = 0;
    bit gaps_on      = 1'b0;
    bit stalls_on    = 1'b0;

    keyed_quantity_table u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic int lookup_slot(input logic [KEY_W-1:0] key);
        for (int s = 0; s < KQT_ENTRIES; s++) begin
            if (tbl_used[s] && tbl_key[s] == key) begin
                return s;
            end
        end
        return -1;
    endfunction

    function automatic logic [COUNT_W-1:0] qty_of(input logic [KEY_W-1:0] key);
        int s;
        s = lookup_slot(key);
        return (s >= 0) ? tbl_qty[s] : '0;
    endfunction

    function automatic t_out apply_request(input t_in req);
        t_out                       rsp;
        int                         s;
        logic [COUNT_W:0]           total;
        logic signed [AMOUNT_W-1:0] amt;
        rsp = '0;
        amt = req.amount;
        s   = lookup_slot(req.item_key);
        case (req.req_type)
            REQ_ADD: begin
                if (req.item_key == '0 || amt <= 0) begin
                    rsp.status = STS_BAD_ARG;
                end else begin
                    if (s >= 0) begin
                        total = {1'b0, tbl_qty[s]} + {1'b0, amt[COUNT_W-1:0]};
                        tbl_qty[s] = total[COUNT_W] ? COUNT_MAX : total[COUNT_W-1:0];
                    end else begin
                        for (int f = KQT_ENTRIES - 1; f >= 0; f--) begin
                            if (!tbl_used[f]) begin
                                s = f;
                            end
                        end
                        if (s < 0) begin
                            rsp.status = STS_FULL;
                        end else begin
                            tbl_used[s] = 1'b1;
                            tbl_key[s]  = req.item_key;
                            tbl_qty[s]  = amt[COUNT_W-1:0];
                        end
                    end
                    if (s >= 0) begin
                        rsp.count   = tbl_qty[s];
                        rsp.changed = 1'b1;
                    end
                end
            end
            REQ_REMOVE: begin
                if (req.item_key == '0 || amt <= 0) begin
                    rsp.status = STS_BAD_ARG;
                end else if (s < 0 || tbl_qty[s] < amt[COUNT_W-1:0]) begin
                    rsp.status = STS_MISSING;
                end else begin
                    tbl_qty[s]  = tbl_qty[s] - amt[COUNT_W-1:0];
                    tbl_used[s] = (tbl_qty[s] != '0);
                    rsp.count   = tbl_qty[s];
                    rsp.changed = 1'b1;
                end
            end
            REQ_QUERY: begin
                if (req.item_key != '0 && s >= 0) begin
                    rsp.count = tbl_qty[s];
                end
                rsp.has_enough = ($signed({1'b0, rsp.count}) >= amt);
            end
            default: begin
                for (int f = 0; f < KQT_ENTRIES; f++) begin
                    tbl_used[f] = 1'b0;
                end
            end
        endcase
        return rsp;
    endfunction

    function automatic t_in make_req(input t_req_kind kind, input logic [KEY_W-1:0] key,
                                     input logic [AMOUNT_W-1:0] amount);
        t_in req;
        req.req_type = kind;
        req.item_key = key;
        req.amount   = amount;
        return req;
    endfunction

    // Amounts lean on the stored quantity of the chosen key so that exact
    // releases, near misses and threshold queries occur often.
    function automatic t_in random_request(input int pool_n);
        t_in                req;
        logic [COUNT_W-1:0] held;
        int                 pick;
        pick = $urandom_range(0, 99);
        req.item_key = key_pool[$urandom_range(0, pool_n - 1)];
        if ($urandom_range(0, 29) == 0) begin
            req.item_key = ($urandom_range(0, 1) == 0) ? '0 : $urandom;
        end
        held = qty_of(req.item_key);
        if (pick < 45) begin
            req.req_type = REQ_ADD;
        end else if (pick < 75) begin
            req.req_type = REQ_REMOVE;
        end else if (pick < 99) begin
            req.req_type = REQ_QUERY;
        end else begin
            req.req_type = REQ_CLEAR;
        end
        case ($urandom_range(0, 9))
            0: req.amount = $urandom;
            1: req.amount = -$urandom_range(0, 3);
            2: req.amount = {1'b0, COUNT_MAX} - $urandom_range(0, 3);
            3, 4, 5: req.amount = {1'b0, held} + $urandom_range(0, 2) - 1;
            default: req.amount = $urandom_range(1, 600);
        endcase
        return req;
    endfunction

    task automatic offer_request(input t_in req);
        if (gaps_on && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in       <= req;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        pending_replies.push_back(apply_request(req));
    endtask

    task automatic test_argument_checks();
        offer_request(make_req(REQ_ADD,    32'h0, 32'sd5));
        offer_request(make_req(REQ_ADD,    32'h1, 32'sd0));
        offer_request(make_req(REQ_ADD,    32'h1, 32'h8000_0000));
        offer_request(make_req(REQ_REMOVE, 32'h0, 32'sd1));
        offer_request(make_req(REQ_REMOVE, 32'h1, 32'hFFFF_FFFF));
        offer_request(make_req(REQ_REMOVE, 32'h1, 32'sd1));
        offer_request(make_req(REQ_QUERY,  32'h0, 32'sd0));
        offer_request(make_req(REQ_QUERY,  32'h0, 32'h8000_0000));
        offer_request(make_req(REQ_QUERY,  32'h0, 32'sd1));
        offer_request(make_req(REQ_CLEAR,  32'hFFFF_FFFF, 32'hFFFF_FFFF));
    endtask

    task automatic test_saturation_and_release();
        offer_request(make_req(REQ_ADD,    32'hFFFF_FFFF, 32'h7FFF_FFFF));
        offer_request(make_req(REQ_ADD,    32'hFFFF_FFFF, 32'sd1));
        offer_request(make_req(REQ_QUERY,  32'hFFFF_FFFF, 32'h7FFF_FFFF));
        offer_request(make_req(REQ_REMOVE, 32'hFFFF_FFFF, 32'h7FFF_FFFF));
        offer_request(make_req(REQ_QUERY,  32'hFFFF_FFFF, 32'sd1));
        offer_request(make_req(REQ_ADD,    32'h1, 32'sd10));
        offer_request(make_req(REQ_REMOVE, 32'h1, 32'sd11));
        offer_request(make_req(REQ_REMOVE, 32'h1, 32'sd4));
        offer_request(make_req(REQ_QUERY,  32'h1, 32'sd7));
    endtask

    task automatic test_table_full();
        logic [KEY_W-1:0] base;
        base = $urandom | 32'h100;
        offer_request(make_req(REQ_CLEAR, '0, '0));
        for (int k = 1; k <= KQT_ENTRIES; k++) begin
            offer_request(make_req(REQ_ADD, base ^ k, $urandom_range(1, 1000)));
        end
        offer_request(make_req(REQ_ADD, base ^ (KQT_ENTRIES + 1), 32'sd9));
        offer_request(make_req(REQ_ADD, base ^ 1, 32'sd5));
        offer_request(make_req(REQ_REMOVE, base ^ 2, {1'b0, qty_of(base ^ 2)}));
        offer_request(make_req(REQ_ADD, base ^ (KQT_ENTRIES + 1), 32'sd9));
        offer_request(make_req(REQ_CLEAR, '1, '1));
    endtask

    task automatic test_random_traffic(input int n_items, input int pool_n, input bit idle);
        gaps_on   = idle;
        stalls_on = idle;
        for (int k = 0; k < POOL_MAX; k++) begin
            key_pool[k] = $urandom;
        end
        repeat (n_items) offer_request(random_request(pool_n));
    endtask

    task automatic test_output_backpressure();
        gaps_on      = 1'b0;
        hold_request = HOLD_CYCLES;
        repeat (12) offer_request(random_request(8));
        gaps_on = 1'b1;
    endtask

    initial begin : drain_pacing
        int span;
        @(posedge i_clk);
        forever begin
            span = 1;
            if (hold_request > 0) begin
                span         = hold_request;
                hold_request = 0;
                i_out_ready <= 1'b0;
            end else if (stalls_on && $urandom_range(0, 4) == 0) begin
                span = $urandom_range(1, 9);
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
            end
            repeat (span) @(posedge i_clk);
        end
    end

    always @(posedge i_clk) begin : result_check
        t_out want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_replies.size() == 0) begin
                $error("result item arrived with no request pending");
                error_count++;
            end else begin
                want = pending_replies.pop_front();
                if (o_out.status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, o_out.status);
                    error_count++;
                end
                if (o_out.count !== want.count) begin
                    $error("count: expected %0d, got %0d", want.count, o_out.count);
                    error_count++;
                end
                if (o_out.has_enough !== want.has_enough) begin
                    $error("has_enough: expected %0b, got %0b",
                           want.has_enough, o_out.has_enough);
                    error_count++;
                end
                if (o_out.changed !== want.changed) begin
                    $error("changed: expected %0b, got %0b", want.changed, o_out.changed);
                    error_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial begin
        for (int s = 0; s < KQT_ENTRIES; s++) begin
            tbl_used[s] = 1'b0;
        end
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        gaps_on   = 1'b1;
        stalls_on = 1'b1;

        test_argument_checks();
        test_saturation_and_release();
        test_table_full();
        test_random_traffic(300, 8, 1'b1);
        test_output_backpressure();
        test_random_traffic(300, 24, 1'b1);
        test_random_traffic(300, 4, 1'b1);
        test_random_traffic(250, 40, 1'b0);

        i_in_valid <= 1'b0;
        while (pending_replies.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
